// ----- rtl/sbcd_pkg.sv -----
// Shared types, byte codes and helpers of the seven-bit command deframer.
// Used by sbcd_ctrl, sbcd_dp and seven_bit_command_deframer; no dependencies.
`default_nettype none

package sbcd_pkg;

  // Defaults for the top-level parameters.
  localparam int BROADCAST_CHANNELS_DEF = 16;
  localparam int STORE_DEPTH_DEF        = 32;

  // Received byte codes.
  localparam logic [7:0] BYTE_SOF_MIN = 8'hAB;  // this value or more opens a frame
  localparam logic [7:0] BYTE_STOP    = 8'h80;

  // Frame header codes.
  localparam logic [7:0] HDR_DEBUG      = 8'hFF;
  localparam logic [7:0] HDR_CHAN_STATE = 8'hDF;
  localparam logic [7:0] HDR_ALL_PARAMS = 8'hDC;
  localparam logic [7:0] HDR_SINGLE_PAR = 8'hDD;
  localparam logic [7:0] HDR_BROADCAST  = 8'hDA;

  localparam logic [7:0] MAX_LEN_RESET = 8'd200;

  // Frame sizes, header included and stop byte excluded.
  localparam logic [7:0] LEN_CHAN_STATE = 8'd4;
  localparam logic [7:0] LEN_SINGLE_PAR = 8'd9;
  localparam logic [7:0] LEN_PARAMS     = 8'd29;
  localparam logic [7:0] LEN_PARAMS_EXT = 8'd30;

  // Highest byte position any command reads.
  localparam int LAST_POS = 28;

  // Result kinds.
  localparam logic [2:0] KIND_CHAN_STATE = 3'd0;
  localparam logic [2:0] KIND_PARAMS     = 3'd1;
  localparam logic [2:0] KIND_PARAMS_EXT = 3'd2;
  localparam logic [2:0] KIND_SINGLE_PAR = 3'd3;
  localparam logic [2:0] KIND_DEBUG      = 3'd4;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_CHECK,
    ST_READ,
    ST_DRAIN,
    ST_EMIT
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic byte_en;   // input item accepted
    logic check_en;  // latch the decision on the closed frame
    logic rd_en;     // read one store entry
    logic chan_inc;  // result taken, advance the broadcast channel
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic stop_seen;  // offered item is a stop byte closing an open frame
    logic chk_debug;
    logic chk_pass;
    logic rd_last;
    logic out_last;
  } dp_status_t;

  // A 32-bit word packed into five seven-bit bytes.
  function automatic logic [31:0] unpack_word(input logic [6:0] b0, input logic [6:0] b1,
                                              input logic [6:0] b2, input logic [6:0] b3,
                                              input logic [6:0] b4);
    return {b0, b1, b2, b3, b4[6:3]};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/seven_bit_command_deframer.sv -----
// Top level of the seven-bit command deframer.
// Depends on sbcd_pkg, sbcd_ctrl and sbcd_dp.
//
// Usage: received bytes enter one item at a time on the in_ channel
// (valid/ready); in_op high aborts an open frame instead of carrying a byte.
// A byte of 0xAB or more opens a frame, seven-bit bytes are stored by
// position, and the stop byte 0x80 closes it. Decoded commands leave on the
// out_ channel (valid/ready), one item per command, or one item per channel
// for a broadcast frame, with out_last marking the final one.
// Bytes inside a frame are taken one per cycle. After a stop byte the block
// checks the header, length and XOR, then reads the 28 stored bytes through
// the single store read port, one per cycle, and shifts each registered read
// into the unpack registers before out_valid rises; a debug frame goes
// straight from the check to its result. Each result then waits for
// out_ready. in_ready stays low from the stop byte until the last result of
// the frame is taken, or until a failed check, so a stalled receiver simply
// holds the block there.
// Reset (rst_n low, synchronous) leaves the parser idle with max_frame_len
// at 200; the byte store is not cleared and needs no clearing pass.
// cfg_we writes max_frame_len from cfg_wdata; write it only while idle.
`default_nettype none

module seven_bit_command_deframer #(
  parameter int BROADCAST_CHANNELS = sbcd_pkg::BROADCAST_CHANNELS_DEF,
  parameter int STORE_DEPTH        = sbcd_pkg::STORE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_op,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_kind,
  output logic [6:0]       out_channel,
  output logic [6:0]       out_selector,
  output logic [31:0]      out_word_a,
  output logic [31:0]      out_word_b,
  output logic [31:0]      out_word_c,
  output logic [31:0]      out_word_d,
  output logic [6:0]       out_pulse_count,
  output logic [31:0]      out_current_bits,
  output logic [6:0]       out_extra_byte,
  output logic             out_last,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata
);

  sbcd_pkg::dp_cmd_t    cmd;
  sbcd_pkg::dp_status_t sts;

  // The controller sequences parsing, checking, store reads and emission.
  sbcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the parser state, the byte store and the result fields.
  sbcd_dp #(
    .BROADCAST_CHANNELS (BROADCAST_CHANNELS),
    .STORE_DEPTH        (STORE_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_op            (in_op),
    .in_rx_byte       (in_rx_byte),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_kind         (out_kind),
    .out_channel      (out_channel),
    .out_selector     (out_selector),
    .out_word_a       (out_word_a),
    .out_word_b       (out_word_b),
    .out_word_c       (out_word_c),
    .out_word_d       (out_word_d),
    .out_pulse_count  (out_pulse_count),
    .out_current_bits (out_current_bits),
    .out_extra_byte   (out_extra_byte),
    .out_last         (out_last)
  );

  // Input is never taken while a result is offered.
  assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
    else $error("input accepted while a result is pending");

  // Once the final result of a frame is taken, the block returns to parsing.
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_valid && out_ready && out_last |=> !out_valid && in_ready)
    else $error("results continue after the final one");

  // A debug result is always a single result with no channel.
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_valid && (out_kind == sbcd_pkg::KIND_DEBUG)
                   |-> out_last && (out_channel == 7'd0))
    else $error("malformed debug result");

  // A result only appears after the parser has stopped taking bytes.
  assert property (@(posedge clk) disable iff (!rst_n)
                   $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared straight out of parsing");

endmodule

`default_nettype wire

// ----- rtl/sbcd_ctrl.sv -----
// Controller state machine of the seven-bit command deframer.
// Depends on sbcd_pkg; drives the command struct of sbcd_dp.
`default_nettype none

module sbcd_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire sbcd_pkg::dp_status_t sts,
  output sbcd_pkg::dp_cmd_t        cmd
);

  sbcd_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sbcd_pkg::ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sbcd_pkg::ST_RUN: begin
        if (in_valid && sts.stop_seen) state_nxt = sbcd_pkg::ST_CHECK;
      end
      sbcd_pkg::ST_CHECK: begin
        priority if (sts.chk_debug) state_nxt = sbcd_pkg::ST_EMIT;
        else if (sts.chk_pass)      state_nxt = sbcd_pkg::ST_READ;
        else                        state_nxt = sbcd_pkg::ST_RUN;
      end
      sbcd_pkg::ST_READ: begin
        if (sts.rd_last) state_nxt = sbcd_pkg::ST_DRAIN;
      end
      sbcd_pkg::ST_DRAIN: begin
        state_nxt = sbcd_pkg::ST_EMIT;
      end
      sbcd_pkg::ST_EMIT: begin
        if (out_ready && sts.out_last) state_nxt = sbcd_pkg::ST_RUN;
      end
      default: state_nxt = sbcd_pkg::ST_RUN;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    cmd          = '0;
    unique case (state_r)
      sbcd_pkg::ST_RUN: begin
        in_ready    = 1'b1;
        cmd.byte_en = in_valid;
      end
      sbcd_pkg::ST_CHECK: begin
        cmd.check_en = 1'b1;
      end
      sbcd_pkg::ST_READ: begin
        cmd.rd_en = 1'b1;
      end
      sbcd_pkg::ST_DRAIN: begin
      end
      sbcd_pkg::ST_EMIT: begin
        out_valid    = 1'b1;
        cmd.chan_inc = out_ready;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/sbcd_dp.sv -----
// Datapath of the seven-bit command deframer: frame parser registers, byte
// store, command check, unpack registers and result fields. Depends on sbcd_pkg.
`default_nettype none

module sbcd_dp #(
  parameter int BROADCAST_CHANNELS = sbcd_pkg::BROADCAST_CHANNELS_DEF,
  parameter int STORE_DEPTH        = sbcd_pkg::STORE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sbcd_pkg::dp_cmd_t cmd,
  output sbcd_pkg::dp_status_t   sts,
  input  wire logic              in_op,
  input  wire logic [7:0]        in_rx_byte,
  input  wire logic              cfg_we,
  input  wire logic [7:0]        cfg_wdata,
  output logic [2:0]             out_kind,
  output logic [6:0]             out_channel,
  output logic [6:0]             out_selector,
  output logic [31:0]            out_word_a,
  output logic [31:0]            out_word_b,
  output logic [31:0]            out_word_c,
  output logic [31:0]            out_word_d,
  output logic [6:0]             out_pulse_count,
  output logic [31:0]            out_current_bits,
  output logic [6:0]             out_extra_byte,
  output logic                   out_last
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int LP = sbcd_pkg::LAST_POS;

  // Parser state.
  logic       in_frame_r;
  logic [7:0] count_r;
  logic [7:0] header_r;
  logic [7:0] xor_r;
  logic [6:0] prev_r;
  logic [7:0] max_len_r;

  // Byte store, its read port and the unpack registers.
  logic [6:0]    store_mem [STORE_DEPTH];
  logic [AW-1:0] raddr_r;
  logic [6:0]    rdata_r;
  logic          rd_pend_r;
  logic [6:0]    bytes_r [1:LP];

  // Decision on the closed frame.
  logic [2:0] kind_r;
  logic       bcast_r;
  logic [6:0] chan_r;

  logic [8:0] count_inc;
  logic       is_data;
  logic [6:0] chk_val;
  logic       chk_ok;
  logic [2:0] chk_kind;
  logic       chk_bcast;
  logic       chk_debug;
  logic       chk_pass;

  assign is_data   = cmd.byte_en && !in_op && (in_rx_byte < sbcd_pkg::BYTE_SOF_MIN)
                     && in_frame_r && !in_rx_byte[7];
  assign count_inc = {1'b0, count_r} + 9'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      count_r    <= '0;
      header_r   <= '0;
      xor_r      <= '0;
      prev_r     <= '0;
      max_len_r  <= sbcd_pkg::MAX_LEN_RESET;
    end else begin
      if (cfg_we) max_len_r <= cfg_wdata;
      if (cmd.byte_en) begin
        priority if (in_op) begin
          in_frame_r <= 1'b0;
        end else if (in_rx_byte >= sbcd_pkg::BYTE_SOF_MIN) begin
          in_frame_r <= 1'b1;
          header_r   <= in_rx_byte;
          xor_r      <= in_rx_byte;
          count_r    <= 8'd1;
        end else if (!in_frame_r) begin
        end else if (in_rx_byte[7]) begin
          in_frame_r <= 1'b0;
        end else begin
          xor_r  <= xor_r ^ in_rx_byte;
          prev_r <= in_rx_byte[6:0];
          if (count_inc > {1'b0, max_len_r}) begin
            in_frame_r <= 1'b0;
            count_r    <= count_inc[8] ? 8'hFF : count_inc[7:0];
          end else begin
            count_r <= count_inc[7:0];
          end
        end
      end
    end
  end

  // Store write and registered read.
  always_ff @(posedge clk) begin
    if (is_data && ({1'b0, count_r} < 9'(STORE_DEPTH))) begin
      store_mem[count_r[AW-1:0]] <= in_rx_byte[6:0];
    end
    if (cmd.rd_en) begin
      rdata_r <= store_mem[raddr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.rd_en;
    end
  end

  // Positions 1 up to the last are shifted in, lowest position first.
  always_ff @(posedge clk) begin
    if (rd_pend_r) begin
      for (int k = 1; k < LP; k++) begin
        bytes_r[k] <= bytes_r[k+1];
      end
      bytes_r[LP] <= rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check_en) begin
      kind_r  <= chk_kind;
      bcast_r <= chk_bcast;
      chan_r  <= '0;
      raddr_r <= AW'(1);
    end else begin
      if (cmd.rd_en)    raddr_r <= raddr_r + AW'(1);
      if (cmd.chan_inc) chan_r  <= chan_r + 7'd1;
    end
  end

  // Length and check of the closed frame.
  assign chk_val = xor_r[6:0] ^ prev_r;
  assign chk_ok  = (count_r >= 8'd2) && (chk_val == prev_r);

  always_comb begin
    chk_debug = 1'b0;
    chk_pass  = 1'b0;
    chk_kind  = sbcd_pkg::KIND_DEBUG;
    chk_bcast = 1'b0;
    unique case (header_r)
      sbcd_pkg::HDR_DEBUG: begin
        chk_debug = 1'b1;
      end
      sbcd_pkg::HDR_CHAN_STATE: begin
        chk_kind = sbcd_pkg::KIND_CHAN_STATE;
        chk_pass = chk_ok && (count_r == sbcd_pkg::LEN_CHAN_STATE);
      end
      sbcd_pkg::HDR_SINGLE_PAR: begin
        chk_kind = sbcd_pkg::KIND_SINGLE_PAR;
        chk_pass = chk_ok && (count_r == sbcd_pkg::LEN_SINGLE_PAR);
      end
      sbcd_pkg::HDR_ALL_PARAMS, sbcd_pkg::HDR_BROADCAST: begin
        chk_kind  = (count_r == sbcd_pkg::LEN_PARAMS_EXT) ? sbcd_pkg::KIND_PARAMS_EXT
                                                           : sbcd_pkg::KIND_PARAMS;
        chk_bcast = (header_r == sbcd_pkg::HDR_BROADCAST);
        chk_pass  = chk_ok && ((count_r == sbcd_pkg::LEN_PARAMS) ||
                               (count_r == sbcd_pkg::LEN_PARAMS_EXT));
      end
      default: begin
      end
    endcase
  end

  assign sts.chk_debug = chk_debug;
  assign sts.chk_pass  = chk_pass;
  assign sts.stop_seen = in_frame_r && !in_op && (in_rx_byte == sbcd_pkg::BYTE_STOP);
  assign sts.rd_last   = (raddr_r == AW'(LP));
  assign sts.out_last  = !bcast_r || (chan_r == 7'(BROADCAST_CHANNELS - 1));

  // Result fields, held steady by the registers above while a result waits.
  always_comb begin
    out_kind         = kind_r;
    out_channel      = '0;
    out_selector     = '0;
    out_word_a       = '0;
    out_word_b       = '0;
    out_word_c       = '0;
    out_word_d       = '0;
    out_pulse_count  = '0;
    out_current_bits = '0;
    out_extra_byte   = '0;
    out_last         = sts.out_last;
    unique case (kind_r)
      sbcd_pkg::KIND_CHAN_STATE: begin
        out_channel  = bytes_r[1];
        out_selector = bytes_r[2] & 7'h07;
      end
      sbcd_pkg::KIND_SINGLE_PAR: begin
        out_channel  = bytes_r[1];
        out_selector = bytes_r[2];
        out_word_a   = sbcd_pkg::unpack_word(bytes_r[3], bytes_r[4], bytes_r[5],
                                             bytes_r[6], bytes_r[7]);
      end
      sbcd_pkg::KIND_PARAMS, sbcd_pkg::KIND_PARAMS_EXT: begin
        out_channel      = bcast_r ? chan_r : bytes_r[1];
        out_word_a       = sbcd_pkg::unpack_word(bytes_r[2], bytes_r[3], bytes_r[4],
                                                 bytes_r[5], bytes_r[6]);
        out_word_b       = sbcd_pkg::unpack_word(bytes_r[7], bytes_r[8], bytes_r[9],
                                                 bytes_r[10], bytes_r[11]);
        out_word_c       = sbcd_pkg::unpack_word(bytes_r[12], bytes_r[13], bytes_r[14],
                                                 bytes_r[15], bytes_r[16]);
        out_word_d       = sbcd_pkg::unpack_word(bytes_r[17], bytes_r[18], bytes_r[19],
                                                 bytes_r[20], bytes_r[21]);
        out_pulse_count  = bytes_r[22];
        out_current_bits = sbcd_pkg::unpack_word(bytes_r[23], bytes_r[24], bytes_r[25],
                                                 bytes_r[26], bytes_r[27]);
        if (kind_r == sbcd_pkg::KIND_PARAMS_EXT) out_extra_byte = bytes_r[28];
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire
